/* design/gvl_pkg.sv */
// Shared constants, codes and types of the gas viscosity law unit.
package gvl_pkg;

    // Field widths
    localparam int TEMP_W  = 32;
    localparam int VISC_W  = 48;
    localparam int EXPO_W  = 20;
    localparam int MODEL_W = 2;
    localparam int CFG_IDX_W = 3;

    // Fixed-point formats
    localparam int TEMP_FRAC_BITS = 16;
    localparam int MU_FRAC_BITS   = 40;
    localparam int EXP_FRAC_BITS  = 16;

    // Model codes
    localparam logic [MODEL_W-1:0] MODEL_CONST = 2'd0;
    localparam logic [MODEL_W-1:0] MODEL_SUTH  = 2'd1;
    localparam logic [MODEL_W-1:0] MODEL_POWER = 2'd2;
    localparam logic [MODEL_W-1:0] MODEL_ARC   = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MU    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TREF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TSUTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OMEGA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 3'd5;

    // Reset values
    localparam logic [MODEL_W-1:0] RST_MODEL = MODEL_SUTH;
    localparam logic [VISC_W-1:0]  RST_MU    = 48'd18867619;
    localparam logic [TEMP_W-1:0]  RST_TREF  = 32'd17901158;
    localparam logic [TEMP_W-1:0]  RST_TSUTH = 32'd7235174;
    localparam logic [EXPO_W-1:0]  RST_OMEGA = 20'd49807;
    localparam logic [EXPO_W-1:0]  RST_GAMMA = 20'd91750;

    // Log domain
    localparam int LOG_IN_W  = 48;
    localparam int NCHUNK    = LOG_IN_W / 16;
    localparam int K_W       = 6;
    localparam int LOG_FRAC  = 32;
    localparam int LOG_W     = K_W + LOG_FRAC;
    localparam int MANT_W    = 63;
    localparam int LOG_LAT   = 2 + 2 * LOG_FRAC;

    // Exponent / exp2
    localparam int EX_W      = 48;
    localparam int TAYLOR_TERMS = 24;
    localparam int EXP_LAT   = 2 + 4 * TAYLOR_TERMS + 1;
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
    localparam int RECIP_SHIFT = 67;

    // Arc law
    localparam int ARC_PAR  = TEMP_FRAC_BITS % 2;
    localparam int ARC_HALF = (16 + TEMP_FRAC_BITS + ARC_PAR) / 2;
    localparam int ARC_LSH  = ARC_PAR + 10;
    localparam int ARC_RSH  = 69 + ARC_HALF - MU_FRAC_BITS;
    localparam int ARC_C_W  = 45;
    localparam logic [ARC_C_W-1:0] ARC_COEF = 45'd27670116110564;
    localparam int ARC_LAT  = 2 + 32 + 2;

    // Pipeline length from entry register to the final select stage
    localparam int CTX_LEN = LOG_LAT + 3 + EXP_LAT + 1;
    localparam int ARC_DLY = CTX_LEN - 1 - ARC_LAT;

    typedef struct packed {
        logic [MODEL_W-1:0] model;
        logic               bad;
        logic               zero;
    } ctx_t;

endpackage

/* design/gas_viscosity_law_unit.sv */
// Gas viscosity law unit: temperature stream in, viscosity stream out.
//
// Input beats carry one temperature (unsigned Q16.16 kelvin) on s_tdata. Each
// beat yields exactly one output beat: viscosity (unsigned Q8.40 Pa*s) on
// m_tdata, with the saturated and bad_setting flags on m_tuser.
// The model and its constants sit in six registers written through the
// cfg_wr_* port; write them only while no beats are in flight.
// The pipeline length is set by the 32 squaring steps (two stages each) of
// the log lanes plus the 24-term exp series (four stages per term). One beat
// per cycle is sustained while the output is taken; the arc law path runs
// alongside and is delayed to match.
// The whole pipeline advances on one enable: when the output register holds
// a beat that is not taken, every stage holds and s_tready drops; nothing is
// lost or repeated. Reset empties the pipeline and loads the default
// registers (Sutherland model with air constants).
module gas_viscosity_law_unit
    import gvl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TEMP_W-1:0]    s_tdata,     // [31:0] temperature
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [VISC_W-1:0]    m_tdata,     // [47:0] viscosity
    output logic [1:0]           m_tuser,     // [0] saturated, [1] bad_setting
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [VISC_W-1:0]    cfg_wr_data
);

    // configuration registers
    logic [MODEL_W-1:0] model_reg;
    logic [VISC_W-1:0]  mu_ref_reg;
    logic [TEMP_W-1:0]  tref_reg;
    logic [TEMP_W-1:0]  tsuth_reg;
    logic [EXPO_W-1:0]  omega_reg;
    logic [EXPO_W-1:0]  gamma_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_reg  <= RST_MODEL;
            mu_ref_reg <= RST_MU;
            tref_reg   <= RST_TREF;
            tsuth_reg  <= RST_TSUTH;
            omega_reg  <= RST_OMEGA;
            gamma_reg  <= RST_GAMMA;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_MODEL: model_reg  <= cfg_wr_data[MODEL_W-1:0];
                REG_MU:    mu_ref_reg <= cfg_wr_data;
                REG_TREF:  tref_reg   <= cfg_wr_data[TEMP_W-1:0];
                REG_TSUTH: tsuth_reg  <= cfg_wr_data[TEMP_W-1:0];
                REG_OMEGA: omega_reg  <= cfg_wr_data[EXPO_W-1:0];
                REG_GAMMA: gamma_reg  <= cfg_wr_data[EXPO_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic               en;
    logic               m_tvalid_reg;
    logic [CTX_LEN-1:0] vld_reg;
    ctx_t               ctx_reg [CTX_LEN];
    ctx_t               ctx_next;
    logic [TEMP_W-1:0]  t_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        ctx_next.model = model_reg;
        ctx_next.bad   = (tref_reg == '0)
                      || (model_reg == MODEL_SUTH && s_tdata == '0 && tsuth_reg == '0);
        ctx_next.zero  = (s_tdata == '0) || (mu_ref_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CTX_LEN-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg      <= s_tdata;
            ctx_reg[0] <= ctx_next;
            for (int i = 1; i < CTX_LEN; i++) begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    // log lanes
    logic [LOG_W-1:0] log_t, log_r, log_a, log_b, log_m;

    gvl_log2 u_log_t (.aclk(aclk), .en(en), .x(LOG_IN_W'(t_reg)), .log_val(log_t));
    gvl_log2 u_log_r (.aclk(aclk), .en(en), .x(LOG_IN_W'(tref_reg)), .log_val(log_r));
    gvl_log2 u_log_a (
        .aclk(aclk), .en(en),
        .x(LOG_IN_W'((TEMP_W+1)'(tref_reg) + (TEMP_W+1)'(tsuth_reg))),
        .log_val(log_a)
    );
    gvl_log2 u_log_b (
        .aclk(aclk), .en(en),
        .x(LOG_IN_W'((TEMP_W+1)'(t_reg) + (TEMP_W+1)'(tsuth_reg))),
        .log_val(log_b)
    );
    gvl_log2 u_log_m (.aclk(aclk), .en(en), .x(mu_ref_reg), .log_val(log_m));

    // exponent assembly, three stages
    logic signed [LOG_W:0]            d_reg;
    logic signed [LOG_W+1:0]          base_reg;
    logic [LOG_W-1:0]                 lm1_reg, lm2_reg;
    logic signed [EX_W-1:0]           ex1_reg, ex_reg;
    logic signed [LOG_W+EXPO_W+1:0]   pw_reg;
    logic signed [EX_W-1:0]           lm_ext;

    assign lm_ext = EX_W'($signed({1'b0, lm2_reg}));

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= $signed({1'b0, log_t}) - $signed({1'b0, log_r});
            base_reg <= $signed({2'b0, log_m}) + $signed({2'b0, log_a})
                      - $signed({2'b0, log_b});
            lm1_reg  <= log_m;

            ex1_reg  <= EX_W'(base_reg) + EX_W'(d_reg) + EX_W'(d_reg >>> 1);
            pw_reg   <= d_reg * $signed({1'b0, omega_reg});
            lm2_reg  <= lm1_reg;

            if (ctx_reg[LOG_LAT+2].model == MODEL_POWER) begin
                ex_reg <= lm_ext + EX_W'(pw_reg >>> EXP_FRAC_BITS);
            end else begin
                ex_reg <= ex1_reg;
            end
        end
    end

    logic [VISC_W-1:0] exp_mu;
    logic              exp_sat;

    gvl_exp2 u_exp (
        .aclk (aclk),
        .en   (en),
        .ex   (ex_reg),
        .mu   (exp_mu),
        .sat  (exp_sat)
    );

    // arc law: isqrt one result bit per stage, then the constant multiply
    logic [51:0]  gt_reg;
    logic [63:0]  v_bnd [33];
    logic [63:0]  r_bnd [33];

    always_ff @(posedge aclk) begin
        if (en) begin
            gt_reg   <= gamma_reg * t_reg;
            v_bnd[0] <= 64'(gt_reg) << ARC_LSH;
            r_bnd[0] <= '0;
        end
    end

    for (genvar i = 0; i < 32; i++) begin : g_isqrt
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * i);
        logic [63:0] rb;

        assign rb = r_bnd[i] + BIT;

        always_ff @(posedge aclk) begin
            if (en) begin
                if (v_bnd[i] >= rb) begin
                    v_bnd[i+1] <= v_bnd[i] - rb;
                    r_bnd[i+1] <= (r_bnd[i] >> 1) + BIT;
                end else begin
                    v_bnd[i+1] <= v_bnd[i];
                    r_bnd[i+1] <= r_bnd[i] >> 1;
                end
            end
        end
    end

    localparam int ARC_PW = 32 + ARC_C_W;

    logic [63:0]            apl_reg;
    logic [ARC_C_W-1:0]     aph_reg;
    logic [ARC_PW-1:0]      arc_prod;
    logic [VISC_W-1:0]      arc_mu_reg;
    logic [VISC_W-1:0]      arc_dly_reg [ARC_DLY];

    // sqrt < 2^31 keeps the scaled product far below the output range
    assign arc_prod = (ARC_PW'(aph_reg) << 32) + ARC_PW'(apl_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            apl_reg        <= r_bnd[32][31:0] * ARC_COEF[31:0];
            aph_reg        <= r_bnd[32][31:0] * ARC_COEF[ARC_C_W-1:32];
            arc_mu_reg     <= VISC_W'(arc_prod[ARC_PW-1:ARC_RSH]);
            arc_dly_reg[0] <= arc_mu_reg;
            for (int i = 1; i < ARC_DLY; i++) begin
                arc_dly_reg[i] <= arc_dly_reg[i-1];
            end
        end
    end

    // final select and output register
    ctx_t              ctx_last;
    logic [VISC_W-1:0] mu_sel;
    logic              sat_sel, bad_sel;

    assign ctx_last = ctx_reg[CTX_LEN-1];

    always_comb begin
        mu_sel  = '0;
        sat_sel = 1'b0;
        bad_sel = 1'b0;
        case (ctx_last.model)
            MODEL_CONST: mu_sel = mu_ref_reg;
            MODEL_ARC:   mu_sel = arc_dly_reg[ARC_DLY-1];
            default: begin
                if (ctx_last.bad) begin
                    bad_sel = 1'b1;
                end else if (!ctx_last.zero) begin
                    mu_sel  = exp_mu;
                    sat_sel = exp_sat;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_reg[CTX_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata <= mu_sel;
            m_tuser <= {bad_sel, sat_sel};
        end
    end

    // checks
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("saturated and bad_setting both set");

    a_bad_gives_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("bad_setting beat with nonzero viscosity");

    a_sat_gives_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '1)
        else $error("saturated beat not at full scale");

    a_entry_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> vld_reg[0])
        else $error("accepted beat missing from entry stage");

endmodule

/* design/gvl_log2.sv */
// Pipelined base-2 logarithm: msb search, then one squaring per fraction bit.
module gvl_log2
    import gvl_pkg::*;
(
    input  logic                aclk,
    input  logic                en,
    input  logic [LOG_IN_W-1:0] x,
    output logic [LOG_W-1:0]    log_val
);

    // msb search, first half: per 16-bit chunk
    logic [LOG_IN_W-1:0] x_reg;
    logic [NCHUNK-1:0]   nz_reg, nz_next;
    logic [3:0]          pos_reg [NCHUNK];
    logic [3:0]          pos_next [NCHUNK];

    always_comb begin
        for (int c = 0; c < NCHUNK; c++) begin
            nz_next[c]  = |x[c*16 +: 16];
            pos_next[c] = '0;
            for (int b = 0; b < 16; b++) begin
                if (x[c*16 + b]) begin
                    pos_next[c] = 4'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= x;
            nz_reg <= nz_next;
            for (int c = 0; c < NCHUNK; c++) begin
                pos_reg[c] <= pos_next[c];
            end
        end
    end

    // boundary registers between squaring steps
    logic [MANT_W-1:0]   m_bnd    [LOG_FRAC+1];
    logic [K_W-1:0]      k_bnd    [LOG_FRAC+1];
    logic [LOG_FRAC-1:0] frac_bnd [LOG_FRAC+1];

    logic [K_W-1:0]    k_next;
    logic [MANT_W-1:0] m_next;

    always_comb begin
        k_next = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            if (nz_reg[c]) begin
                k_next = K_W'(c * 16) + K_W'(pos_reg[c]);
            end
        end
        m_next = MANT_W'(x_reg) << (K_W'(MANT_W - 1) - k_next);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_bnd[0]    <= m_next;
            k_bnd[0]    <= k_next;
            frac_bnd[0] <= '0;
        end
    end

    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_step
        logic [61:0]         p11_reg;
        logic [62:0]         p10_reg;
        logic [63:0]         p00_reg;
        logic [K_W-1:0]      k_reg;
        logic [LOG_FRAC-1:0] frac_reg;
        logic [125:0]        full;
        logic [63:0]         sq;

        always_ff @(posedge aclk) begin
            if (en) begin
                p11_reg  <= m_bnd[j][62:32] * m_bnd[j][62:32];
                p10_reg  <= m_bnd[j][62:32] * m_bnd[j][31:0];
                p00_reg  <= m_bnd[j][31:0] * m_bnd[j][31:0];
                k_reg    <= k_bnd[j];
                frac_reg <= frac_bnd[j];
            end
        end

        // square >> 62; a set top bit means the square reached two
        assign full = (126'(p11_reg) << 64) + (126'(p10_reg) << 33) + 126'(p00_reg);
        assign sq   = full[125:62];

        always_ff @(posedge aclk) begin
            if (en) begin
                m_bnd[j+1]    <= sq[63] ? sq[63:1] : sq[62:0];
                k_bnd[j+1]    <= k_reg;
                frac_bnd[j+1] <= {frac_reg[LOG_FRAC-2:0], sq[63]};
            end
        end
    end

    assign log_val = {k_bnd[LOG_FRAC], frac_bnd[LOG_FRAC]};

endmodule

/* design/gvl_exp2.sv */
// Pipelined 2^E: ln2 scaling, Taylor series for e^u, final shift and saturation.
module gvl_exp2
    import gvl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   en,
    input  logic signed [EX_W-1:0] ex,
    output logic [VISC_W-1:0]      mu,
    output logic                   sat
);

    localparam int N_W  = EX_W - LOG_FRAC;
    localparam int TM_W = 63;
    localparam int U_W  = 62;
    localparam int SM_W = 64;
    localparam int RCP_W = 68;

    typedef struct packed {
        logic           big;
        logic           neg;
        logic [K_W-1:0] nsh;
    } exp_flag_t;

    logic signed [N_W-1:0] n;
    exp_flag_t             flg_next;
    exp_flag_t             flg_reg [EXP_LAT-1];
    logic [63:0]           pf0_reg, pf1_reg;

    assign n = ex[EX_W-1:LOG_FRAC];

    always_comb begin
        flg_next.big = (n >= $signed(N_W'(VISC_W)));
        flg_next.neg = n[N_W-1];
        flg_next.nsh = K_W'(62) - n[K_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pf0_reg    <= ex[LOG_FRAC-1:0] * LN2_Q64[31:0];
            pf1_reg    <= ex[LOG_FRAC-1:0] * LN2_Q64[63:32];
            flg_reg[0] <= flg_next;
            for (int i = 1; i < EXP_LAT - 1; i++) begin
                flg_reg[i] <= flg_reg[i-1];
            end
        end
    end

    logic [95:0]     uprod;
    logic [TM_W-1:0] term_bnd [TAYLOR_TERMS+1];
    logic [SM_W-1:0] sum_bnd  [TAYLOR_TERMS+1];
    logic [U_W-1:0]  u_bnd    [TAYLOR_TERMS+1];

    assign uprod = (96'(pf1_reg) << 32) + 96'(pf0_reg);

    // first term is 2^62, which needs the extra top bit of the term lane
    always_ff @(posedge aclk) begin
        if (en) begin
            u_bnd[0]    <= uprod[95:34];
            term_bnd[0] <= TM_W'(1) << 62;
            sum_bnd[0]  <= SM_W'(1) << 62;
        end
    end

    for (genvar j = 0; j < TAYLOR_TERMS; j++) begin : g_term
        localparam int K = j + 1;
        localparam logic [RCP_W:0] NUM = ((RCP_W+1)'(1) << RECIP_SHIFT) + (RCP_W+1)'(K - 1);
        localparam logic [RCP_W-1:0] RECIP = RCP_W'(NUM / (RCP_W+1)'(K));

        // term * u, four partial products
        logic [60:0]     a11_reg;
        logic [62:0]     a10_reg;
        logic [61:0]     a01_reg;
        logic [63:0]     a00_reg;
        logic [SM_W-1:0] s1_reg, s2_reg, s3_reg;
        logic [U_W-1:0]  u1_reg, u2_reg, u3_reg;
        logic [123:0]    afull;
        logic [U_W-1:0]  p_reg;
        // p / K through the reciprocal, six partial products
        logic [63:0]     q00_reg, q01_reg;
        logic [35:0]     q02_reg;
        logic [61:0]     q10_reg, q11_reg;
        logic [33:0]     q12_reg;
        logic [129:0]    qfull;

        always_ff @(posedge aclk) begin
            if (en) begin
                a11_reg <= term_bnd[j][62:32] * u_bnd[j][61:32];
                a10_reg <= term_bnd[j][62:32] * u_bnd[j][31:0];
                a01_reg <= term_bnd[j][31:0] * u_bnd[j][61:32];
                a00_reg <= term_bnd[j][31:0] * u_bnd[j][31:0];
                s1_reg  <= sum_bnd[j];
                u1_reg  <= u_bnd[j];
            end
        end

        assign afull = (124'(a11_reg) << 64) + (124'(a10_reg) << 32)
                     + (124'(a01_reg) << 32) + 124'(a00_reg);

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg  <= afull[123:62];
                s2_reg <= s1_reg;
                u2_reg <= u1_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q00_reg <= p_reg[31:0] * RECIP[31:0];
                q01_reg <= p_reg[31:0] * RECIP[63:32];
                q02_reg <= p_reg[31:0] * RECIP[67:64];
                q10_reg <= p_reg[61:32] * RECIP[31:0];
                q11_reg <= p_reg[61:32] * RECIP[63:32];
                q12_reg <= p_reg[61:32] * RECIP[67:64];
                s3_reg  <= s2_reg;
                u3_reg  <= u2_reg;
            end
        end

        assign qfull = 130'(q00_reg) + (130'(q01_reg) << 32) + (130'(q02_reg) << 64)
                     + (130'(q10_reg) << 32) + (130'(q11_reg) << 64)
                     + (130'(q12_reg) << 96);

        always_ff @(posedge aclk) begin
            if (en) begin
                term_bnd[j+1] <= qfull[RECIP_SHIFT +: TM_W];
                sum_bnd[j+1]  <= s3_reg + SM_W'(qfull[RECIP_SHIFT +: TM_W]);
                u_bnd[j+1]    <= u3_reg;
            end
        end
    end

    exp_flag_t       flg_last;
    logic [SM_W-1:0] shifted;

    assign flg_last = flg_reg[EXP_LAT-2];
    assign shifted  = sum_bnd[TAYLOR_TERMS] >> flg_last.nsh;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (flg_last.big) begin
                mu  <= '1;
                sat <= 1'b1;
            end else if (flg_last.neg) begin
                mu  <= '0;
                sat <= 1'b0;
            end else begin
                mu  <= shifted[VISC_W-1:0];
                sat <= 1'b0;
            end
        end
    end

endmodule
